// ===== rtl/lerc_pkg.sv =====
// Package for the leading-edge rise-time classifier.
// Holds field widths, register indexes, status codes, state types and the interpolator request.
// No dependencies.
package lerc_pkg;

  localparam int TIME_W     = 20;
  localparam int AMP_W      = 16;
  localparam int GAIN_W     = 12;
  localparam int OFS_W      = 12;
  localparam int LTH_W      = 16;
  localparam int L2_W       = 15;
  localparam int DIFF_W     = 17;
  localparam int DEN_W      = 17;
  localparam int PROD_W     = DIFF_W + TIME_W;
  localparam int CLS_W      = 4;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int LOOKAHEAD_DEF   = 10;
  localparam int NUM_CLASSES_DEF = 8;

  localparam logic [GAIN_W-1:0] GAIN_RST = 12'd275;
  localparam logic [OFS_W-1:0]  OFS_RST  = 12'd96;
  localparam logic [LTH_W-1:0]  LTH_RST  = 16'd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN      = 2'd0,
    REG_OFFSET    = 2'd1,
    REG_LASER_THR = 2'd2
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_NO_LASER = 2'd0,
    ST_NO_EDGE  = 2'd1,
    ST_NO_PEAK  = 2'd2,
    ST_OK       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_RUN,
    S_INTERP,
    S_CLASS,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    I_IDLE,
    I_MUL,
    I_DIV,
    I_DONE
  } interp_state_t;

  typedef struct packed {
    logic [DIFF_W-1:0] diff;
    logic [DEN_W-1:0]  den;
    logic [TIME_W-1:0] dt_mag;
    logic              dt_neg;
    logic [TIME_W-1:0] t_prev;
  } interp_req_t;

endpackage

// ===== rtl/lerc_cell.sv =====
// One cell of the sample window: holds one amplitude and time, passes them on each transaction.
// Flags whether the incoming amplitude reaches the reference amplitude.
// Depends on lerc_pkg.
module lerc_cell (
  input  logic                               clk,
  input  logic                               shift,
  input  logic signed [lerc_pkg::AMP_W-1:0]  din_amp,
  input  logic        [lerc_pkg::TIME_W-1:0] din_time,
  input  logic signed [lerc_pkg::AMP_W-1:0]  ref_amp,
  output logic signed [lerc_pkg::AMP_W-1:0]  amp_q,
  output logic        [lerc_pkg::TIME_W-1:0] time_q,
  output logic                               ge
);

  always_ff @(posedge clk) begin
    if (shift) begin
      amp_q  <= din_amp;
      time_q <= din_time;
    end
  end

  assign ge = (din_amp >= ref_amp);

endmodule

// ===== rtl/lerc_interp.sv =====
// Edge-time interpolator: one multiply, a one-bit-per-cycle restoring divide, then a signed add.
// Takes a request struct on start and pulses done with the edge time.
// Depends on lerc_pkg.
module lerc_interp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lerc_pkg::interp_req_t         req,
  output logic                          done,
  output logic [lerc_pkg::TIME_W-1:0]   edge_time
);

  localparam int CNT_W = $clog2(lerc_pkg::TIME_W);

  lerc_pkg::interp_state_t state, state_next;
  lerc_pkg::interp_req_t   req_q;
  logic [CNT_W-1:0]                 cnt;
  logic [lerc_pkg::DEN_W-1:0]       rem;
  logic [lerc_pkg::TIME_W-1:0]      qb;
  logic [lerc_pkg::PROD_W-1:0]      prod;
  logic [lerc_pkg::DEN_W:0]         trial;
  logic                             take;

  assign prod  = lerc_pkg::PROD_W'(req_q.diff) * lerc_pkg::PROD_W'(req_q.dt_mag);
  assign trial = {rem, qb[lerc_pkg::TIME_W-1]};
  assign take  = (trial >= {1'b0, req_q.den});

  always_comb begin
    state_next = state;
    case (state)
      lerc_pkg::I_IDLE: if (start) state_next = lerc_pkg::I_MUL;
      lerc_pkg::I_MUL:  state_next = lerc_pkg::I_DIV;
      lerc_pkg::I_DIV:  if (cnt == CNT_W'(lerc_pkg::TIME_W - 1)) state_next = lerc_pkg::I_DONE;
      lerc_pkg::I_DONE: state_next = lerc_pkg::I_IDLE;
      default:          state_next = lerc_pkg::I_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lerc_pkg::I_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lerc_pkg::I_IDLE: begin
        if (start) req_q <= req;
        cnt <= '0;
      end
      lerc_pkg::I_MUL: begin
        rem <= prod[lerc_pkg::PROD_W-1:lerc_pkg::TIME_W];
        qb  <= prod[lerc_pkg::TIME_W-1:0];
      end
      lerc_pkg::I_DIV: begin
        rem <= take ? lerc_pkg::DEN_W'(trial - {1'b0, req_q.den})
                    : trial[lerc_pkg::DEN_W-1:0];
        qb  <= {qb[lerc_pkg::TIME_W-2:0], take};
        cnt <= cnt + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    done      = (state == lerc_pkg::I_DONE);
    edge_time = req_q.t_prev + (req_q.dt_neg ? (~qb + lerc_pkg::TIME_W'(1)) : qb);
  end

endmodule

// ===== rtl/leading_edge_rise_time_classifier_top.sv =====
// Top level of the leading-edge rise-time classifier.
// Depends on lerc_pkg, lerc_cell (sample window chain) and lerc_interp (edge-time divider).
//
// Usage:
//   Samples enter on the s_ channel, one transaction per sample; s_tlast marks the final
//   sample of a waveform. One result per waveform leaves on the m_ channel after the
//   sample marked last. Registers are written on cfg_we; the user must write them only
//   while the block is idle, as the block itself does not enforce this. Throughput: one
//   sample per cycle outside the interpolation, band search and result states. The sample on
//   which the signal crosses the leading-edge level holds s_tready low while lerc_interp
//   runs its multiply, 20 divide iterations and the final add. The last sample is
//   followed by a band search over 1 to NUM_CLASSES bands, one band per cycle, then the
//   output register is loaded as soon as no earlier result is still waiting in it.
//   A stalled receiver holds the result in the output register; samples of the next
//   waveform are still taken, and only the next result waits for the register.
//   Reset returns the registers to their defaults and clears the waveform flags and counters;
//   the window cells need no clearing since only samples of the current waveform
//   are ever compared.
module leading_edge_rise_time_classifier_top #(
  parameter int LOOKAHEAD   = lerc_pkg::LOOKAHEAD_DEF,
  parameter int NUM_CLASSES = lerc_pkg::NUM_CLASSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // sample_time[19:0], signal_amplitude[35:20], laser_amplitude[51:36], zero pad
  input  logic [lerc_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // event_status[1:0], rise_time[21:2], edge_time[41:22], peak_amplitude[57:42],
  // pe_class[61:58], zero pad
  output logic [lerc_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_we,
  input  logic [lerc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lerc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int TW     = lerc_pkg::TIME_W;
  localparam int AW     = lerc_pkg::AMP_W;
  localparam int WIN    = LOOKAHEAD + 1;
  localparam int SE_W   = $clog2(LOOKAHEAD + 2);
  localparam int BW_RAW = lerc_pkg::GAIN_W + $clog2(2 * NUM_CLASSES + 2) + 2;
  localparam int BW     = (BW_RAW > AW + 2) ? BW_RAW : AW + 2;

  // configuration
  logic        [lerc_pkg::GAIN_W-1:0] gain;
  logic signed [lerc_pkg::OFS_W-1:0]  pedestal_offset;
  logic signed [lerc_pkg::LTH_W-1:0]  laser_threshold;

  // waveform state
  lerc_pkg::state_t  state, state_next;
  logic              first_seen, laser_crossed, edge_found, peak_found, last_pend;
  logic signed [AW-1:0] prev_laser, peak_amp;
  logic [TW-1:0]     peak_time, edge_time_reg;
  logic [SE_W-1:0]   since_edge, since_next;
  logic signed [BW-1:0] lo;
  logic [lerc_pkg::CLS_W-1:0] cls;

  // input fields
  logic [TW-1:0]        s_t;
  logic signed [AW-1:0] s_a, s_la;
  logic                 accept;

  // window chain
  logic signed [AW-1:0] cell_amp  [LOOKAHEAD];
  logic [TW-1:0]        cell_time [LOOKAHEAD];
  logic [LOOKAHEAD-1:0] cell_ge;

  // edge and peak logic
  logic signed [lerc_pkg::L2_W-1:0] l2;
  logic signed [AW+1:0] a2x, ap2x, l2x, diff_x;
  logic signed [AW:0]   da;
  logic signed [TW:0]   dt;
  logic                 edge_hit, edge_eff, is_max, laser_hit, peak_hit;
  lerc_pkg::interp_req_t req;
  logic                 interp_done;
  logic [TW-1:0]        interp_edge;

  // classification and output
  logic signed [BW-1:0] a2c, m2, hi, lo_init;
  logic                 band_hit, class_end, emit_go;
  lerc_pkg::status_t    status;
  logic signed [TW:0]   rise_d;
  logic [TW-1:0]        rise_o, edge_o;
  logic signed [AW-1:0] pa_o;
  logic [lerc_pkg::CLS_W-1:0] cls_o;

  assign s_t    = s_tdata[TW-1:0];
  assign s_a    = s_tdata[TW+AW-1:TW];
  assign s_la   = s_tdata[TW+2*AW-1:TW+AW];
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain            <= lerc_pkg::GAIN_RST;
      pedestal_offset <= lerc_pkg::OFS_RST;
      laser_threshold <= lerc_pkg::LTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lerc_pkg::REG_GAIN:      gain            <= cfg_data[lerc_pkg::GAIN_W-1:0];
        lerc_pkg::REG_OFFSET:    pedestal_offset <= cfg_data[lerc_pkg::OFS_W-1:0];
        lerc_pkg::REG_LASER_THR: laser_threshold <= cfg_data[lerc_pkg::LTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < LOOKAHEAD; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        lerc_cell u_cell (
          .clk      (clk),
          .shift    (accept),
          .din_amp  (s_a),
          .din_time (s_t),
          .ref_amp  (cell_amp[LOOKAHEAD-1]),
          .amp_q    (cell_amp[gi]),
          .time_q   (cell_time[gi]),
          .ge       (cell_ge[gi])
        );
      end else begin : g_body
        lerc_cell u_cell (
          .clk      (clk),
          .shift    (accept),
          .din_amp  (cell_amp[gi-1]),
          .din_time (cell_time[gi-1]),
          .ref_amp  (cell_amp[LOOKAHEAD-1]),
          .amp_q    (cell_amp[gi]),
          .time_q   (cell_time[gi]),
          .ge       (cell_ge[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    l2     = {pedestal_offset[lerc_pkg::OFS_W-1], pedestal_offset[lerc_pkg::OFS_W-1],
              pedestal_offset, 1'b0} + {3'b000, gain};
    l2x    = (AW+2)'(l2);
    a2x    = {s_a[AW-1], s_a, 1'b0};
    ap2x   = {cell_amp[0][AW-1], cell_amp[0], 1'b0};
    diff_x = l2x - ap2x;
    da     = {s_a[AW-1], s_a} - {cell_amp[0][AW-1], cell_amp[0]};
    dt     = {1'b0, s_t} - {1'b0, cell_time[0]};
    edge_hit  = first_seen && !edge_found && (a2x > l2x) && (ap2x <= l2x);
    edge_eff  = edge_found || edge_hit;
    laser_hit = first_seen && (s_la > laser_threshold) && (prev_laser <= laser_threshold);
    is_max    = ~|cell_ge;
    if (edge_hit) begin
      since_next = SE_W'(1);
    end else if (since_edge < SE_W'(WIN)) begin
      since_next = since_edge + SE_W'(1);
    end else begin
      since_next = since_edge;
    end
    peak_hit = edge_eff && !peak_found && (since_next == SE_W'(WIN)) && is_max;

    req.diff   = diff_x[lerc_pkg::DIFF_W-1:0];
    req.den    = {da[AW-1:0], 1'b0};
    req.dt_neg = dt[TW];
    req.dt_mag = dt[TW] ? TW'(-dt) : dt[TW-1:0];
    req.t_prev = cell_time[0];
  end

  lerc_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && edge_hit),
    .req       (req),
    .done      (interp_done),
    .edge_time (interp_edge)
  );

  always_comb begin
    a2c      = BW'($signed({peak_amp, 1'b0}));
    m2       = BW'({gain, 1'b0});
    lo_init  = BW'($signed({pedestal_offset, 1'b0})) - BW'(gain);
    hi       = lo + m2;
    band_hit = (a2c >= lo) && (a2c < hi);
    class_end = band_hit || (cls == lerc_pkg::CLS_W'(NUM_CLASSES - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lerc_pkg::S_RUN: begin
        if (accept) begin
          if (edge_hit) state_next = lerc_pkg::S_INTERP;
          else if (s_tlast) state_next = lerc_pkg::S_CLASS;
        end
      end
      lerc_pkg::S_INTERP: begin
        if (interp_done) state_next = last_pend ? lerc_pkg::S_CLASS : lerc_pkg::S_RUN;
      end
      lerc_pkg::S_CLASS: if (class_end) state_next = lerc_pkg::S_EMIT;
      lerc_pkg::S_EMIT:  if (emit_go) state_next = lerc_pkg::S_RUN;
      default:           state_next = lerc_pkg::S_RUN;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = (state == lerc_pkg::S_RUN);
    emit_go  = (state == lerc_pkg::S_EMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lerc_pkg::S_RUN;
      first_seen    <= 1'b0;
      laser_crossed <= 1'b0;
      edge_found    <= 1'b0;
      peak_found    <= 1'b0;
      last_pend     <= 1'b0;
      since_edge    <= '0;
      cls           <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        first_seen <= 1'b1;
        last_pend  <= s_tlast;
        if (laser_hit) laser_crossed <= 1'b1;
        if (edge_hit) edge_found <= 1'b1;
        if (edge_eff && !peak_found) since_edge <= since_next;
        if (peak_hit) peak_found <= 1'b1;
      end
      if (state == lerc_pkg::S_CLASS) begin
        if (!band_hit) cls <= cls + lerc_pkg::CLS_W'(1);
      end else if (state != lerc_pkg::S_EMIT) begin
        cls <= '0;
      end
      if (emit_go) begin
        m_tvalid      <= 1'b1;
        first_seen    <= 1'b0;
        laser_crossed <= 1'b0;
        edge_found    <= 1'b0;
        peak_found    <= 1'b0;
        last_pend     <= 1'b0;
        since_edge    <= '0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) prev_laser <= s_la;
    if (accept && peak_hit) begin
      peak_amp  <= cell_amp[LOOKAHEAD-1];
      peak_time <= cell_time[LOOKAHEAD-1];
    end
    if (interp_done) edge_time_reg <= interp_edge;
    if (state == lerc_pkg::S_CLASS) lo <= hi;
    else lo <= lo_init;
    if (emit_go) begin
      m_tdata <= {2'b00, cls_o, pa_o, edge_o, rise_o, status};
    end
  end

  always_comb begin
    if (!laser_crossed) status = lerc_pkg::ST_NO_LASER;
    else if (!edge_found) status = lerc_pkg::ST_NO_EDGE;
    else if (!peak_found) status = lerc_pkg::ST_NO_PEAK;
    else status = lerc_pkg::ST_OK;
    rise_d = {1'b0, peak_time} - {1'b0, edge_time_reg};
    edge_o = '0;
    rise_o = '0;
    pa_o   = '0;
    cls_o  = '0;
    if (status == lerc_pkg::ST_NO_PEAK || status == lerc_pkg::ST_OK) edge_o = edge_time_reg;
    if (status == lerc_pkg::ST_OK) begin
      rise_o = rise_d[TW] ? '0 : rise_d[TW-1:0];
      pa_o   = peak_amp;
      cls_o  = cls;
    end
  end

  a_done_in_interp: assert property (@(posedge clk) disable iff (rst)
    interp_done |-> state == lerc_pkg::S_INTERP)
    else $error("interpolator finished outside its wait state");

  a_peak_after_edge: assert property (@(posedge clk) disable iff (rst)
    peak_found |-> edge_found && since_edge == SE_W'(WIN))
    else $error("peak flagged without edge or full look-ahead");

  a_cls_range: assert property (@(posedge clk) disable iff (rst)
    cls <= lerc_pkg::CLS_W'(NUM_CLASSES))
    else $error("class index beyond band count");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> !first_seen && !edge_found && state == lerc_pkg::S_RUN)
    else $error("waveform state not cleared after result");

endmodule
